FILE: hdl/register_mask_cover_table_unit_macros.svh
// Assertion macros shared by the register mask cover table RTL.
`ifndef REGISTER_MASK_COVER_TABLE_UNIT_MACROS_SVH
`define REGISTER_MASK_COVER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmct assertion failed");

// Next-cycle implication, disabled during reset.
`define RMCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmct assertion failed");

`endif

FILE: hdl/rmct_pkg.sv
// Types, codes and helpers for the register mask cover table.
`default_nettype none

package rmct_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  typedef struct packed {
    logic        action;
    logic [31:0] reg_mask;
    logic [63:0] target_address;
    logic [15:0] stack_amount;
    logic        landing_pad;
    logic [31:0] committed_mask;
    logic        strict_match;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] entry_mask;
    logic [63:0] entry_address;
    logic [15:0] entry_stack;
    logic        entry_pad;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [63:0] addr;
    logic [15:0] stack;
    logic        pad;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic en;
  } scan_ctl_t;

  typedef struct packed {
    logic found;
    logic dup;
  } scan_flag_t;

  // Adder-tree popcount of a 32-bit mask.
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rmct_cell.sv
// One table slot: holds an entry, rotates it to the neighbour or takes a write.
`default_nettype none

module rmct_cell
  import rmct_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift_en,
  input  wire entry_t nbr_entry,
  input  wire logic   wr_en,
  input  wire entry_t wr_entry,
  output entry_t      entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) begin
      entry_nxt = nbr_entry;
    end else if (wr_en) begin
      entry_nxt = wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

FILE: hdl/rmct_scan.sv
// Scan unit: examines the entry at the head of the chain, one slot per cycle.
`default_nettype none

module rmct_scan
  import rmct_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scan_ctl_t        ctl,
  input  wire logic             prefer_pad,
  input  wire in_req_t          req,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [CNT_W-1:0] step,
  input  wire entry_t           head,
  output scan_flag_t            flags,
  output logic [IDX_W-1:0]      best_idx,
  output entry_t                best_entry,
  output logic [IDX_W-1:0]      dup_idx
);

  scan_flag_t       flags_r, flags_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [5:0]       lead_pop_r, lead_pop_nxt;
  entry_t           best_r, best_nxt;
  logic [IDX_W-1:0] dup_idx_r, dup_idx_nxt;

  logic       in_use;
  logic       qualify;
  logic       is_dup;
  logic       take;
  logic [5:0] pop;

  always_comb begin
    in_use  = step < count;
    pop     = popcount32(head.mask);
    qualify = in_use && (req.action == ACT_QUERY)
              && ((head.mask & req.reg_mask) == req.reg_mask)
              && ((head.mask & req.committed_mask) == 32'd0)
              && (!req.strict_match || (head.mask == req.reg_mask));
    is_dup  = in_use && (req.action == ACT_INSERT)
              && (head.addr == req.target_address) && (head.mask == req.reg_mask);
    take    = qualify && (!flags_r.found || (pop < lead_pop_r)
              || ((pop == lead_pop_r) && prefer_pad && head.pad && !best_r.pad));

    flags_nxt    = flags_r;
    best_idx_nxt = best_idx_r;
    lead_pop_nxt = lead_pop_r;
    best_nxt     = best_r;
    dup_idx_nxt  = dup_idx_r;
    if (ctl.clear) begin
      flags_nxt = '0;
    end else if (ctl.en) begin
      if (take) begin
        flags_nxt.found = 1'b1;
        best_idx_nxt    = step[IDX_W-1:0];
        lead_pop_nxt    = pop;
        best_nxt        = head;
      end
      // keep the first matching slot only
      if (is_dup && !flags_r.dup) begin
        flags_nxt.dup = 1'b1;
        dup_idx_nxt   = step[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    lead_pop_r <= lead_pop_nxt;
    best_r     <= best_nxt;
    dup_idx_r  <= dup_idx_nxt;
  end

  assign flags      = flags_r;
  assign best_idx   = best_idx_r;
  assign best_entry = best_r;
  assign dup_idx    = dup_idx_r;

endmodule

`default_nettype wire

FILE: hdl/register_mask_cover_table_unit.sv
// Top level of the register mask cover table: cell chain, scan unit and control.
`default_nettype none

// Register mask cover table. The table lives in a ring of TABLE_DEPTH cells,
// one entry per cell. Every insert (unless the table is already full) and
// every query rotates the ring one full turn, one cell per cycle, so that each
// slot passes the scan unit at the head of the ring in slot order; after the
// turn every entry is back in its home cell. The scan unit keeps the first
// duplicate slot for inserts and the best covering entry for queries. A new
// entry is written into its home cell (count_r) once the turn is over and
// the result register is free. A request goes through the rotation and then
// a decision step before its result is registered; an insert into a full
// table skips the rotation. One request is in flight at a time, but the next
// one is taken while the previous result still waits under stall.
// No clearing pass is needed after reset: only slots below the entry count
// are ever looked at. Write prefer_landing_pad through cfg_wr_en/cfg_wr_data
// only while the block is idle.

module register_mask_cover_table_unit
  import rmct_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_rsp_t      out_rsp,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data
);

`include "register_mask_cover_table_unit_macros.svh"

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             prefer_r, prefer_nxt;
  logic             full_r, full_nxt;
  in_req_t          req_r, req_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  logic             in_take;
  logic             fin_go;
  logic             shift_en;
  logic             wr_go;
  scan_ctl_t        scan_ctl;
  scan_flag_t       scan_flags;
  logic [IDX_W-1:0] best_idx;
  logic [IDX_W-1:0] dup_idx;
  entry_t           best_entry;
  entry_t           wr_entry;
  entry_t           cells [TABLE_DEPTH];
  logic [31:0]      best_idx_w, dup_idx_w, count_w;

  // Ring of cells: cell i takes its entry from cell i+1, so cell 0 is the head.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NBR = (i + 1) % TABLE_DEPTH;
    rmct_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .nbr_entry (cells[NBR]),
      .wr_en     (wr_go && (count_r == CNT_W'(i))),
      .wr_entry  (wr_entry),
      .entry     (cells[i])
    );
  end

  rmct_scan #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .prefer_pad (prefer_r),
    .req        (req_r),
    .count      (count_r),
    .step       (step_r),
    .head       (cells[0]),
    .flags      (scan_flags),
    .best_idx   (best_idx),
    .best_entry (best_entry),
    .dup_idx    (dup_idx)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign shift_en = (state_r == S_SCAN);
  // the result register must be free before the decision is committed
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign wr_go    = fin_go && (req_r.action == ACT_INSERT) && !full_r && !scan_flags.dup;

  assign scan_ctl.clear = in_take;
  assign scan_ctl.en    = shift_en;

  assign wr_entry.mask  = req_r.reg_mask;
  assign wr_entry.addr  = req_r.target_address;
  assign wr_entry.stack = req_r.stack_amount;
  assign wr_entry.pad   = req_r.landing_pad;

  assign best_idx_w = 32'(best_idx);
  assign dup_idx_w  = 32'(dup_idx);
  assign count_w    = 32'(count_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    prefer_nxt    = prefer_r;
    full_nxt      = full_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;

    if (cfg_wr_en) begin
      prefer_nxt = cfg_wr_data;
    end

    // drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          req_nxt  = in_req;
          step_nxt = '0;
          full_nxt = (in_req.action == ACT_INSERT) && (count_r == FULL_CNT);
          // a full table needs no scan
          state_nxt = ((in_req.action == ACT_INSERT) && (count_r == FULL_CNT))
                      ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          if (req_r.action == ACT_INSERT) begin
            if (full_r) begin
              out_rsp_nxt.status = ST_FULL;
            end else if (scan_flags.dup) begin
              out_rsp_nxt.status      = ST_DUPLICATE;
              out_rsp_nxt.entry_index = dup_idx_w[5:0];
            end else begin
              out_rsp_nxt.status      = ST_INSERTED;
              out_rsp_nxt.entry_index = count_w[5:0];
              count_nxt               = count_r + CNT_W'(1);
            end
          end else if (scan_flags.found) begin
            out_rsp_nxt.status        = ST_FOUND;
            out_rsp_nxt.entry_index   = best_idx_w[5:0];
            out_rsp_nxt.entry_mask    = best_entry.mask;
            out_rsp_nxt.entry_address = best_entry.addr;
            out_rsp_nxt.entry_stack   = best_entry.stack;
            out_rsp_nxt.entry_pad     = best_entry.pad;
          end else begin
            out_rsp_nxt.status = ST_NONE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      prefer_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prefer_r    <= prefer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and bookkeeping that every request reloads
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    full_r    <= full_nxt;
    req_r     <= req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `RMCT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT)
  `RMCT_ASSERT_NEXT(a_scan_runs, clk, rst_n, (state_r == S_SCAN) && (step_r != LAST_STEP), state_r == S_SCAN)
  `RMCT_ASSERT_NEXT(a_take_starts, clk, rst_n, in_take, state_r != S_IDLE)
  `RMCT_ASSERT_NOW(a_write_free, clk, rst_n, wr_go, (count_r != FULL_CNT) && !shift_en)

endmodule

`default_nettype wire
